// File: rtl/preos_pkg.sv
// Shared types and constants for the point-reflection even/odd splitter.
package preos_pkg;

  localparam int unsigned MAX_SIDE = 128;
  localparam int unsigned CNT_W    = $clog2(MAX_SIDE);
  localparam int unsigned SIDE_W   = CNT_W + 1;
  localparam int unsigned IDX_W    = 2 * CNT_W;
  localparam int unsigned VAL_W    = 16;
  localparam int unsigned SUM_W    = VAL_W + 1;
  localparam int unsigned MIN_SIDE = 2;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SIDE_W-1:0] side_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  typedef enum logic [1:0] {
    KIND_STORE = 2'd0,
    KIND_SELF  = 2'd1,
    KIND_PAIR  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e kind;
    idx_t  pidx;
    idx_t  midx;
  } item_t;

endpackage

// File: rtl/point_reflection_even_odd_split_top.sv
// Top level of the point-reflection even/odd splitter.
// Pixels of a square frame enter in raster order, one per transaction; a pixel whose
// mirror is still ahead is written to a 16384 x 16 pixel store, a self-mirrored pixel
// yields one result, and a pixel whose mirror was seen yields two (itself, then the
// mirror) as doubled even and odd parts. Results leave through the single output
// register, which carries one result per cycle while out_stall_i is low; a taken pixel
// is held in a stage register before its results are loaded into the output register.
// The store needs no clearing after reset. Writing frame_side (clamped to 2..128)
// restarts the frame at pixel zero and is taken only while the block is idle and no
// pixel is offered.
module point_reflection_even_odd_split_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [15:0]  pixel_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [13:0]         pixel_index_o,
  output logic signed [16:0]  even_twice_o,
  output logic signed [16:0]  odd_twice_o,
  output logic                last_of_run_o
);

  preos_pkg::item_t item;
  preos_pkg::idx_t  waddr, raddr;
  preos_pkg::val_t  rdata;
  logic             take, idle, accept, cfg_we;

  assign accept      = in_valid_i && take;
  assign in_stall_o  = !take;
  assign cfg_ready_o = idle && !in_valid_i;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  preos_addr u_addr (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .item_o     (item),
    .waddr_o    (waddr),
    .raddr_o    (raddr)
  );

  // a mirror is always written at an earlier edge than its read, so no forwarding
  preos_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (accept && (item.kind == preos_pkg::KIND_STORE)),
    .waddr_i (waddr),
    .wdata_i (pixel_value_i),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  preos_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .item_i        (item),
    .val_i         (pixel_value_i),
    .rdata_i       (rdata),
    .take_o        (take),
    .idle_o        (idle),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_index_o (pixel_index_o),
    .even_twice_o  (even_twice_o),
    .odd_twice_o   (odd_twice_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// File: rtl/preos_addr.sv
// Raster counters, frame side register and mirror address generation.
module preos_addr (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                accept_i,
  output preos_pkg::item_t    item_o,
  output preos_pkg::idx_t     waddr_o,
  output preos_pkg::idx_t     raddr_o
);

  preos_pkg::side_t side_q, side_d;
  preos_pkg::cnt_t  col_q, col_d, row_q, row_d;
  preos_pkg::cnt_t  mcol, mrow;
  preos_pkg::side_t col_inc, row_inc;
  logic [2*preos_pkg::SIDE_W-1:0] prow, mprow, psum, msum;
  logic             is_self, is_later;

  // clamp the written side into the supported range
  always_comb begin
    side_d = preos_pkg::side_t'(preos_pkg::MAX_SIDE);
    if (cfg_data_i < 8'(preos_pkg::MIN_SIDE)) begin
      side_d = preos_pkg::side_t'(preos_pkg::MIN_SIDE);
    end else if (cfg_data_i <= 8'(preos_pkg::MAX_SIDE)) begin
      side_d = preos_pkg::side_t'(cfg_data_i);
    end
  end

  assign col_inc = preos_pkg::side_t'(col_q) + 1'b1;
  assign row_inc = preos_pkg::side_t'(row_q) + 1'b1;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
    end else if (accept_i) begin
      if (col_inc >= side_q) begin
        col_d = '0;
        row_d = (row_inc >= side_q) ? '0 : preos_pkg::cnt_t'(row_inc);
      end else begin
        col_d = preos_pkg::cnt_t'(col_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= preos_pkg::side_t'(preos_pkg::MAX_SIDE);
      col_q  <= '0;
      row_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        side_q <= side_d;
      end
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign mcol = (col_q == '0) ? '0 : preos_pkg::cnt_t'(side_q - preos_pkg::side_t'(col_q));
  assign mrow = (row_q == '0) ? '0 : preos_pkg::cnt_t'(side_q - preos_pkg::side_t'(row_q));

  assign prow  = (2*preos_pkg::SIDE_W)'(row_q) * (2*preos_pkg::SIDE_W)'(side_q);
  assign mprow = (2*preos_pkg::SIDE_W)'(mrow) * (2*preos_pkg::SIDE_W)'(side_q);
  assign psum  = prow + (2*preos_pkg::SIDE_W)'(col_q);
  assign msum  = mprow + (2*preos_pkg::SIDE_W)'(mcol);

  // columns stay below side, so raster order is row first, then column
  assign is_self  = (mrow == row_q) && (mcol == col_q);
  assign is_later = (mrow > row_q) || ((mrow == row_q) && (mcol > col_q));

  always_comb begin
    item_o.pidx = psum[preos_pkg::IDX_W-1:0];
    item_o.midx = msum[preos_pkg::IDX_W-1:0];
    if (is_self) begin
      item_o.kind = preos_pkg::KIND_SELF;
    end else if (is_later) begin
      item_o.kind = preos_pkg::KIND_STORE;
    end else begin
      item_o.kind = preos_pkg::KIND_PAIR;
    end
  end

  assign waddr_o = {row_q, col_q};
  assign raddr_o = {mrow, mcol};

  a_col_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (preos_pkg::side_t'(col_q) < side_q) && (preos_pkg::side_t'(row_q) < side_q))
    else $error("raster counter outside frame");

endmodule

// File: rtl/preos_mem.sv
// Pixel store: single-port-write, registered-read synchronous memory.
module preos_mem (
  input  logic            clk_i,
  input  logic            we_i,
  input  preos_pkg::idx_t waddr_i,
  input  preos_pkg::val_t wdata_i,
  input  logic            re_i,
  input  preos_pkg::idx_t raddr_i,
  output preos_pkg::val_t rdata_o
);

  preos_pkg::val_t mem [preos_pkg::MAX_SIDE*preos_pkg::MAX_SIDE];
  preos_pkg::val_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/preos_out.sv
// Result sequencer: holds one pixel and emits its results through an output register.
module preos_out (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  preos_pkg::item_t        item_i,
  input  preos_pkg::val_t         val_i,
  input  preos_pkg::val_t         rdata_i,
  output logic                    take_o,
  output logic                    idle_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output preos_pkg::idx_t         pixel_index_o,
  output preos_pkg::sum_t         even_twice_o,
  output preos_pkg::sum_t         odd_twice_o,
  output logic                    last_of_run_o
);

  logic             s1_valid_q, s1_phase_q;
  preos_pkg::item_t s1_item_q;
  preos_pkg::val_t  s1_val_q;
  logic             out_valid_q, out_last_q, out_last_d;
  preos_pkg::idx_t  out_idx_q, out_idx_d;
  preos_pkg::sum_t  out_even_q, out_even_d, out_odd_q, out_odd_d;
  preos_pkg::sum_t  v17, s17;
  logic             out_load, s1_done;

  assign out_load = s1_valid_q && (s1_item_q.kind != preos_pkg::KIND_STORE)
                 && (!out_valid_q || !out_stall_i);
  assign s1_done  = s1_valid_q && ((s1_item_q.kind == preos_pkg::KIND_STORE) ||
                    (out_load && ((s1_item_q.kind == preos_pkg::KIND_SELF) || s1_phase_q)));
  assign take_o   = !s1_valid_q || s1_done;
  assign idle_o   = !s1_valid_q && !out_valid_q;

  assign v17 = preos_pkg::SUM_W'(s1_val_q);
  assign s17 = preos_pkg::SUM_W'(rdata_i);

  always_comb begin
    out_idx_d  = s1_item_q.pidx;
    out_even_d = v17 + s17;
    out_odd_d  = v17 - s17;
    out_last_d = 1'b0;
    unique case (s1_item_q.kind)
      preos_pkg::KIND_SELF: begin
        out_even_d = v17 + v17;
        out_odd_d  = '0;
        out_last_d = 1'b1;
      end
      preos_pkg::KIND_PAIR: begin
        // second result reports the mirror pixel
        if (s1_phase_q) begin
          out_idx_d  = s1_item_q.midx;
          out_odd_d  = s17 - v17;
          out_last_d = 1'b1;
        end
      end
      default: begin
        out_last_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_phase_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept_i) begin
        s1_valid_q <= 1'b1;
        s1_phase_q <= 1'b0;
      end else if (s1_done) begin
        s1_valid_q <= 1'b0;
        s1_phase_q <= 1'b0;
      end else if (out_load) begin
        s1_phase_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_item_q <= item_i;
      s1_val_q  <= val_i;
    end
    if (out_load) begin
      out_idx_q  <= out_idx_d;
      out_even_q <= out_even_d;
      out_odd_q  <= out_odd_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_index_o = out_idx_q;
  assign even_twice_o  = out_even_q;
  assign odd_twice_o   = out_odd_q;
  assign last_of_run_o = out_last_q;

  a_phase_only_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_phase_q |-> (s1_valid_q && (s1_item_q.kind == preos_pkg::KIND_PAIR)))
    else $error("second phase without a pair pixel");

  a_first_has_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_last_q) |-> (s1_valid_q && s1_phase_q))
    else $error("first result of a pair shown without its mirror pending");

  a_pair_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (s1_item_q.kind == preos_pkg::KIND_PAIR) && !s1_phase_q) |=> s1_phase_q)
    else $error("pair did not advance to its mirror result");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |-> (!s1_valid_q || s1_done))
    else $error("pixel accepted over unfinished work");

endmodule
